// ===== sv/kuz_pkg.sv =====
// Package: Kuznyechik constants, S-box and linear transform functions.
package kuz_pkg;

  localparam int ROUNDS_DEF = 9;
  localparam int KEY_STEPS = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0 = 3'd0,
    REG_KEY1 = 3'd1,
    REG_KEY2 = 3'd2,
    REG_KEY3 = 3'd3,
    REG_IV_LO = 3'd4,
    REG_IV_HI = 3'd5,
    REG_REVERSE = 3'd6
  } cfg_reg_t;

  localparam logic [7:0] SBOX [256] = '{
    8'd252, 8'd238, 8'd221, 8'd17, 8'd207, 8'd110, 8'd49, 8'd22,
    8'd251, 8'd196, 8'd250, 8'd218, 8'd35, 8'd197, 8'd4, 8'd77,
    8'd233, 8'd119, 8'd240, 8'd219, 8'd147, 8'd46, 8'd153, 8'd186,
    8'd23, 8'd54, 8'd241, 8'd187, 8'd20, 8'd205, 8'd95, 8'd193,
    8'd249, 8'd24, 8'd101, 8'd90, 8'd226, 8'd92, 8'd239, 8'd33,
    8'd129, 8'd28, 8'd60, 8'd66, 8'd139, 8'd1, 8'd142, 8'd79,
    8'd5, 8'd132, 8'd2, 8'd174, 8'd227, 8'd106, 8'd143, 8'd160,
    8'd6, 8'd11, 8'd237, 8'd152, 8'd127, 8'd212, 8'd211, 8'd31,
    8'd235, 8'd52, 8'd44, 8'd81, 8'd234, 8'd200, 8'd72, 8'd171,
    8'd242, 8'd42, 8'd104, 8'd162, 8'd253, 8'd58, 8'd206, 8'd204,
    8'd181, 8'd112, 8'd14, 8'd86, 8'd8, 8'd12, 8'd118, 8'd18,
    8'd191, 8'd114, 8'd19, 8'd71, 8'd156, 8'd183, 8'd93, 8'd135,
    8'd21, 8'd161, 8'd150, 8'd41, 8'd16, 8'd123, 8'd154, 8'd199,
    8'd243, 8'd145, 8'd120, 8'd111, 8'd157, 8'd158, 8'd178, 8'd177,
    8'd50, 8'd117, 8'd25, 8'd61, 8'd255, 8'd53, 8'd138, 8'd126,
    8'd109, 8'd84, 8'd198, 8'd128, 8'd195, 8'd189, 8'd13, 8'd87,
    8'd223, 8'd245, 8'd36, 8'd169, 8'd62, 8'd168, 8'd67, 8'd201,
    8'd215, 8'd121, 8'd214, 8'd246, 8'd124, 8'd34, 8'd185, 8'd3,
    8'd224, 8'd15, 8'd236, 8'd222, 8'd122, 8'd148, 8'd176, 8'd188,
    8'd220, 8'd232, 8'd40, 8'd80, 8'd78, 8'd51, 8'd10, 8'd74,
    8'd167, 8'd151, 8'd96, 8'd115, 8'd30, 8'd0, 8'd98, 8'd68,
    8'd26, 8'd184, 8'd56, 8'd130, 8'd100, 8'd159, 8'd38, 8'd65,
    8'd173, 8'd69, 8'd70, 8'd146, 8'd39, 8'd94, 8'd85, 8'd47,
    8'd140, 8'd163, 8'd165, 8'd125, 8'd105, 8'd213, 8'd149, 8'd59,
    8'd7, 8'd88, 8'd179, 8'd64, 8'd134, 8'd172, 8'd29, 8'd247,
    8'd48, 8'd55, 8'd107, 8'd228, 8'd136, 8'd217, 8'd231, 8'd137,
    8'd225, 8'd27, 8'd131, 8'd73, 8'd76, 8'd63, 8'd248, 8'd254,
    8'd141, 8'd83, 8'd170, 8'd144, 8'd202, 8'd216, 8'd133, 8'd97,
    8'd32, 8'd113, 8'd103, 8'd164, 8'd45, 8'd43, 8'd9, 8'd91,
    8'd203, 8'd155, 8'd37, 8'd208, 8'd190, 8'd229, 8'd108, 8'd82,
    8'd89, 8'd166, 8'd116, 8'd210, 8'd230, 8'd244, 8'd180, 8'd192,
    8'd209, 8'd102, 8'd175, 8'd194, 8'd57, 8'd75, 8'd99, 8'd182
  };

  localparam logic [7:0] LCOEF [16] = '{
    8'd1, 8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1,
    8'd251, 8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148
  };

  function automatic logic [7:0] gf_mul(input logic [7:0] a_in, input logic [7:0] b_in);
    logic [7:0] a;
    logic [7:0] p;
    a = a_in;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b_in[i]) p = p ^ a;
      a = a[7] ? ((a << 1) ^ 8'hc3) : (a << 1);
    end
    return p;
  endfunction

  // Full L transform: sixteen R steps unrolled.
  function automatic logic [127:0] lin(input logic [127:0] s_in);
    logic [127:0] s;
    logic [7:0] acc;
    s = s_in;
    for (int r = 0; r < 16; r++) begin
      acc = 8'h00;
      for (int i = 0; i < 16; i++) acc = acc ^ gf_mul(s[8*i +: 8], LCOEF[i]);
      s = {acc, s[127:8]};
    end
    return s;
  endfunction

  function automatic logic [127:0] sub_lin(input logic [127:0] s_in);
    logic [127:0] s;
    for (int i = 0; i < 16; i++) s[8*i +: 8] = SBOX[s_in[8*i +: 8]];
    return lin(s);
  endfunction

  function automatic logic [127:0] byte_rev(input logic [127:0] s);
    logic [127:0] r;
    for (int i = 0; i < 16; i++) r[8*i +: 8] = s[8*(15-i) +: 8];
    return r;
  endfunction

endpackage

// ===== sv/kuznyechik_ctr_cipher.sv =====
// Top level: Kuznyechik counter-mode cipher with round keys in a synchronous memory.
// Rounds: one round per cycle, with the round key read ahead from the key memory.
// The round loop reads the key memory; no new block is taken until the previous result has been accepted.
// Key writes rerun the schedule; no request is taken until the schedule has finished writing the keys.
// Reset: synchronous, active high; clears key, iv, counter and reverse flag and expands the zero key.
module kuznyechik_ctr_cipher #(
  parameter int ROUNDS = kuz_pkg::ROUNDS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [127:0] s_tdata, // data_low, data_high
  input  logic s_tuser,         // restart
  input  logic s_tlast,         // last_block
  output logic m_tvalid,
  input  logic m_tready,
  output logic [127:0] m_tdata, // result_low, result_high
  output logic m_tlast,         // result_last
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [kuz_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kuz_pkg::CFG_DATA_W-1:0] cfg_data
);
  import kuz_pkg::*;

  localparam int NKEYS = ROUNDS + 1;
  localparam int KA_W = $clog2(NKEYS);
  localparam int RC_W = $clog2(NKEYS + 1);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} state_t;

  logic [255:0] key;
  logic [127:0] iv;
  logic reverse;
  logic [127:0] ctr;
  logic ks_start;
  logic ks_busy;
  logic ks_wr;
  logic [KA_W-1:0] ks_addr;
  logic [127:0] ks_data;

  logic [127:0] kmem [NKEYS];
  logic [KA_W-1:0] rd_addr;
  logic [127:0] rk;

  state_t state;
  logic [RC_W-1:0] rnd;
  logic [127:0] s;
  logic [127:0] din;
  logic lastb;

  kuz_keysched #(.NKEYS(NKEYS), .KA_W(KA_W)) u_ks (
    .clk(clk), .rst(rst), .start(ks_start), .key(key), .busy(ks_busy),
    .wr_en(ks_wr), .wr_addr(ks_addr), .wr_data(ks_data)
  );

  always_ff @(posedge clk) begin
    if (ks_wr) kmem[ks_addr] <= ks_data;
    rk <= kmem[rd_addr];
  end

  assign cfg_ready = (state == S_IDLE);
  assign s_tready = (state == S_IDLE) && !ks_busy && !ks_wr && !ks_start && !cfg_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
      iv <= '0;
      ctr <= '0;
      reverse <= 1'b0;
      ks_start <= 1'b0;
    end else begin
      ks_start <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_KEY0: begin key[63:0] <= cfg_data; ks_start <= 1'b1; end
          REG_KEY1: begin key[127:64] <= cfg_data; ks_start <= 1'b1; end
          REG_KEY2: begin key[191:128] <= cfg_data; ks_start <= 1'b1; end
          REG_KEY3: begin key[255:192] <= cfg_data; ks_start <= 1'b1; end
          REG_IV_LO: begin iv[63:0] <= cfg_data; ctr[63:0] <= cfg_data; end
          REG_IV_HI: begin iv[127:64] <= cfg_data; ctr[127:64] <= cfg_data; end
          REG_REVERSE: reverse <= cfg_data[0];
          default: ;
        endcase
      end else if (s_tvalid && s_tready) begin
        ctr <= (s_tuser ? iv : ctr) + 128'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      rnd <= '0;
      rd_addr <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            s <= s_tuser ? iv : ctr;
            din <= s_tdata;
            lastb <= s_tlast;
            rnd <= '0;
            rd_addr <= KA_W'(1);
            state <= S_RUN;
          end else begin
            rd_addr <= '0;
          end
        end
        S_RUN: begin
          rnd <= rnd + 1'b1;
          if (32'(rd_addr) + 1 < NKEYS) rd_addr <= rd_addr + 1'b1;
          if (32'(rnd) == ROUNDS) begin
            m_tdata <= din ^ (reverse ? byte_rev(s ^ rk) : (s ^ rk));
            m_tlast <= lastb;
            m_tvalid <= 1'b1;
            state <= S_OUT;
          end else begin
            s <= sub_lin(s ^ rk);
          end
        end
        S_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            rd_addr <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_only_in_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> state == S_OUT) else $error("result valid outside output state");
  a_no_accept_in_sched: assert property (@(posedge clk) disable iff (rst)
    ks_busy |-> !s_tready) else $error("request taken during key schedule");
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && 32'(rnd) == ROUNDS) |=> m_tvalid) else $error("round count overrun");
endmodule

// ===== sv/kuz_keysched.sv =====
// Key schedule: one Feistel step a cycle, writes round keys into the key memory.
module kuz_keysched #(
  parameter int NKEYS = kuz_pkg::ROUNDS_DEF + 1,
  parameter int KA_W = $clog2(NKEYS)
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [255:0] key,
  output logic         busy,
  output logic         wr_en,
  output logic [KA_W-1:0] wr_addr,
  output logic [127:0] wr_data
);
  import kuz_pkg::*;

  localparam int STEP_W = $clog2(KEY_STEPS + 2);

  logic [127:0] a;
  logic [127:0] b;
  logic [STEP_W-1:0] step;
  logic [127:0] c;
  logic [127:0] t;
  logic [KA_W:0] kidx;
  logic [127:0] c_in;
  logic pend;
  logic [KA_W-1:0] pend_addr;

  always_comb begin
    c_in = '0;
    c_in[7:0] = 8'(step - STEP_W'(2) + 1'b1);
    c = lin(c_in);
    t = sub_lin(a ^ c) ^ b;
    kidx = (KA_W + 1)'(((step - STEP_W'(2)) >> 3) * 2 + 2);
  end

  // step 0/1 write the raw key halves; steps 2..33 run the Feistel network;
  // the second key of each pair is written from b in the cycle after the first
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      step <= '0;
      wr_en <= 1'b0;
      a <= '0;
      b <= '0;
      pend <= 1'b0;
    end else begin
      wr_en <= 1'b0;
      pend <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        a <= key[255:128];
        b <= key[127:0];
      end else if (busy) begin
        step <= step + 1'b1;
        if (pend) begin
          wr_en <= 1'b1;
          wr_addr <= pend_addr;
          wr_data <= b;
        end
        if (step == 0) begin
          wr_en <= 1'b1;
          wr_addr <= '0;
          wr_data <= a;
        end else if (step == 1) begin
          wr_en <= 1'b1;
          wr_addr <= KA_W'(1);
          wr_data <= b;
        end else if (step == STEP_W'(KEY_STEPS + 2)) begin
          busy <= 1'b0;
        end else begin
          a <= t;
          b <= a;
          if (step[2:0] == 3'd1 && 32'(kidx) + 1 < NKEYS) begin
            wr_en <= 1'b1;
            wr_addr <= KA_W'(kidx);
            wr_data <= t;
            pend <= 1'b1;
            pend_addr <= KA_W'(kidx + 1'b1);
          end
        end
      end
    end
  end
endmodule

// ===== tb/tb_kuznyechik_ctr_cipher.sv =====
// Testbench for the Kuznyechik counter-mode cipher: predicted keystream XOR checked per block.
module tb_kuznyechik_ctr_cipher;
  timeunit 1ns;
  timeprecision 1ps;
  import kuz_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic [7:0] PI_TAB [256] = '{
    252, 238, 221, 17, 207, 110, 49, 22, 251, 196, 250, 218, 35, 197, 4, 77,
    233, 119, 240, 219, 147, 46, 153, 186, 23, 54, 241, 187, 20, 205, 95, 193,
    249, 24, 101, 90, 226, 92, 239, 33, 129, 28, 60, 66, 139, 1, 142, 79,
    5, 132, 2, 174, 227, 106, 143, 160, 6, 11, 237, 152, 127, 212, 211, 31,
    235, 52, 44, 81, 234, 200, 72, 171, 242, 42, 104, 162, 253, 58, 206, 204,
    181, 112, 14, 86, 8, 12, 118, 18, 191, 114, 19, 71, 156, 183, 93, 135,
    21, 161, 150, 41, 16, 123, 154, 199, 243, 145, 120, 111, 157, 158, 178, 177,
    50, 117, 25, 61, 255, 53, 138, 126, 109, 84, 198, 128, 195, 189, 13, 87,
    223, 245, 36, 169, 62, 168, 67, 201, 215, 121, 214, 246, 124, 34, 185, 3,
    224, 15, 236, 222, 122, 148, 176, 188, 220, 232, 40, 80, 78, 51, 10, 74,
    167, 151, 96, 115, 30, 0, 98, 68, 26, 184, 56, 130, 100, 159, 38, 65,
    173, 69, 70, 146, 39, 94, 85, 47, 140, 163, 165, 125, 105, 213, 149, 59,
    7, 88, 179, 64, 134, 172, 29, 247, 48, 55, 107, 228, 136, 217, 231, 137,
    225, 27, 131, 73, 76, 63, 248, 254, 141, 83, 170, 144, 202, 216, 133, 97,
    32, 113, 103, 164, 45, 43, 9, 91, 203, 155, 37, 208, 190, 229, 108, 82,
    89, 166, 116, 210, 230, 244, 180, 192, 209, 102, 175, 194, 57, 75, 99, 182
  };
  localparam logic [7:0] FEEDBACK [16] = '{
    1, 148, 32, 133, 16, 194, 192, 1, 251, 1, 192, 194, 16, 133, 32, 148
  };

  typedef struct {
    logic [127:0] text;
    logic         last;
  } cipher_block_t;

  class ctr_scoreboard;
    logic [63:0]   key_w [4];
    logic [127:0]  iv;
    logic [127:0]  counter;
    logic          reverse;
    logic [127:0]  rkeys [10];
    cipher_block_t pending [$];
    int            errors;
    int            checked;

    function automatic logic [7:0] gmul(logic [7:0] x, logic [7:0] y);
      logic [7:0] acc;
      acc = 0;
      for (int i = 0; i < 8; i++) begin
        if (y[i]) acc ^= x;
        x = x[7] ? ((x << 1) ^ 8'hc3) : (x << 1);
      end
      return acc;
    endfunction

    function automatic logic [127:0] mix(logic [127:0] v);
      logic [7:0] fb;
      for (int r = 0; r < 16; r++) begin
        fb = 0;
        for (int i = 0; i < 16; i++) fb ^= gmul(v[8*i +: 8], FEEDBACK[i]);
        v = {fb, v[127:8]};
      end
      return v;
    endfunction

    function automatic logic [127:0] round_fn(logic [127:0] v);
      for (int i = 0; i < 16; i++) v[8*i +: 8] = PI_TAB[v[8*i +: 8]];
      return mix(v);
    endfunction

    function void schedule();
      logic [127:0] a, b, t, c;
      a = {key_w[3], key_w[2]};
      b = {key_w[1], key_w[0]};
      rkeys[0] = a;
      rkeys[1] = b;
      for (int s = 0; s < KEY_STEPS; s++) begin
        c = mix(128'(s + 1));
        t = round_fn(a ^ c) ^ b;
        b = a;
        a = t;
        if (s % 8 == 7) begin
          rkeys[2*(s/8) + 2] = a;
          rkeys[2*(s/8) + 3] = b;
        end
      end
    endfunction

    function new();
      foreach (key_w[i]) key_w[i] = 0;
      iv = 0;
      counter = 0;
      reverse = 0;
      errors = 0;
      checked = 0;
      schedule();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
      case (idx)
        REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
          key_w[idx] = val;
          schedule();
        end
        REG_IV_LO: begin
          iv[63:0] = val;
          counter[63:0] = val;
        end
        REG_IV_HI: begin
          iv[127:64] = val;
          counter[127:64] = val;
        end
        REG_REVERSE: reverse = val[0];
        default: ;
      endcase
    endfunction

    function void note_block(logic [127:0] text, logic restart, logic last);
      logic [127:0] ks, rv;
      cipher_block_t e;
      if (restart) counter = iv;
      ks = counter;
      for (int r = 0; r < ROUNDS_DEF; r++) ks = round_fn(ks ^ rkeys[r]);
      ks ^= rkeys[ROUNDS_DEF];
      if (reverse) begin
        for (int i = 0; i < 16; i++) rv[8*i +: 8] = ks[8*(15-i) +: 8];
        ks = rv;
      end
      counter = counter + 1;
      e.text = text ^ ks;
      e.last = last;
      pending.push_back(e);
    endfunction

    function void check_block(logic [127:0] text, logic last);
      cipher_block_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h last %b", $time, text, last);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (text !== e.text) begin
        $display("%0t: data expected %h actual %h", $time, e.text, text);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last expected %b actual %b", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, s_tuser, s_tlast;
  logic [127:0] s_tdata;
  logic m_tvalid, m_tready, m_tlast;
  logic [127:0] m_tdata;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ctr_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  int blocks_sent = 0;
  int reg_writes = 0;

  kuznyechik_ctr_cipher u_top (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (m_tvalid && m_tready) sb.check_block(m_tdata, m_tlast);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  task automatic send_block(logic [127:0] text, logic restart, logic last);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= text;
    s_tuser <= restart;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_block(text, restart, last);
    blocks_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(int n);
    logic [127:0] text;
    for (int i = 0; i < n; i++) begin
      text = {$urandom, $urandom, $urandom, $urandom};
      send_block(text, $urandom_range(9) == 0, $urandom_range(7) == 0);
    end
  endtask

  task automatic settle();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 70; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 70; end
      default: begin idle_pct = 8; stall_pct = 8; end
    endcase
  endtask

  initial begin
    rst = 1;
    s_tvalid = 0;
    s_tdata = 0;
    s_tuser = 0;
    s_tlast = 0;
    m_tready = 0;
    cfg_valid = 0;
    cfg_index = REG_KEY0;
    cfg_data = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // zero key after reset, field extremes
    send_block('0, 0, 0);
    send_block('1, 0, 1);
    send_block({64'h0, {64{1'b1}}}, 1, 0);
    send_block({{64{1'b1}}, 64'h0}, 0, 1);
    send_block({4{32'haaaa5555}}, 1, 1);
    settle();

    // counter wrap with reversed keystream
    write_reg(REG_IV_LO, '1);
    write_reg(REG_IV_HI, '1);
    write_reg(REG_REVERSE, 64'd1);
    send_block('0, 1, 0);
    send_block('1, 0, 0);
    send_block({4{32'h5555aaaa}}, 0, 1);
    settle();

    // carry from low to high counter word only
    write_reg(REG_IV_HI, 64'h0);
    send_block('0, 0, 0);
    send_block('0, 1, 0);
    send_block('1, 0, 1);
    settle();

    // unknown index ignored, all-ones key
    write_reg(REG_UNUSED, '1);
    write_reg(REG_KEY0, '1);
    write_reg(REG_KEY1, '1);
    write_reg(REG_KEY2, '1);
    write_reg(REG_KEY3, '1);
    write_reg(REG_REVERSE, 64'd0);
    send_block('0, 1, 0);
    send_block('1, 0, 1);
    send_block({$urandom, $urandom, $urandom, $urandom}, 0, 0);
    settle();

    for (int ph = 0; ph < 12; ph++) begin
      set_idling(ph);
      write_reg(REG_KEY0, rand64());
      write_reg(REG_KEY1, rand64());
      write_reg(REG_KEY2, rand64());
      write_reg(REG_KEY3, rand64());
      write_reg(REG_IV_LO, (ph % 3 == 0) ? ~64'($urandom_range(40)) : rand64());
      write_reg(REG_IV_HI, (ph == 5) ? '1 : rand64());
      write_reg(REG_REVERSE, 64'(ph % 2));
      if (ph == 7) write_reg(REG_UNUSED, rand64());
      send_random(120);
      settle();
    end

    set_idling(0);
    $display("Sent %0d blocks over %0d register writes, checked %0d results,",
             blocks_sent, reg_writes, sb.checked);
    $display("covering counter wrap, restarts, reversed keystream and stalls on both sides.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/kuz_pkg.sv
sv/kuz_keysched.sv
sv/kuznyechik_ctr_cipher.sv
tb/tb_kuznyechik_ctr_cipher.sv
